// ===== src/turtle_pen_plotter_unit_assert.svh =====
// Assertion macros shared by the plotter checker.
`ifndef TURTLE_PEN_PLOTTER_UNIT_ASSERT_SVH
`define TURTLE_PEN_PLOTTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plotter check failed");

// Consequent must hold in the cycle after the antecedent.
`define TPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plotter check failed");

`endif

// ===== src/tpp_pkg.sv =====
// Shared types, codes and constants of the turtle pen plotter.
package tpp_pkg;

	localparam int GRID_SIZE_DEF = 64;
	localparam int MODE_W        = 3;
	localparam int DIST_W        = 10;
	localparam int KIND_W        = 2;
	localparam int CRD_W         = 6;
	localparam int ROW_BITS_W    = 64;
	localparam int HEAD_W        = 2;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [MODE_W-1:0] MODE_PEN_UP   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PEN_DOWN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MOVE     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUMP     = 3'd5;
	localparam logic [MODE_W-1:0] MODE_EXIT     = 3'd6;

	localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ROW = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD = 2'd2;

	localparam logic [HEAD_W-1:0] HEAD_PX = 2'd0;
	localparam logic [HEAD_W-1:0] HEAD_PY = 2'd1;
	localparam logic [HEAD_W-1:0] HEAD_NX = 2'd2;

	typedef enum logic [2:0] {
		OP_PEN_UP,
		OP_PEN_DOWN,
		OP_RIGHT,
		OP_LEFT,
		OP_MOVE,
		OP_DUMP,
		OP_NOP,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [DIST_W-1:0] move_len;
	} cmd_t;

endpackage

// ===== src/tpp_front.sv =====
// Command front end: accepts input beats and classifies them into queue entries.
module tpp_front (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tpp_pkg::MODE_W-1:0]  mode,
	input  logic [tpp_pkg::DIST_W-1:0]  distance,
	input  logic                        q_full,
	output logic                        q_push,
	output tpp_pkg::cmd_t               q_data
);
	import tpp_pkg::*;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.move_len = distance;
		unique case (mode)
			MODE_PEN_UP:   q_data.op = OP_PEN_UP;
			MODE_PEN_DOWN: q_data.op = OP_PEN_DOWN;
			MODE_RIGHT:    q_data.op = OP_RIGHT;
			MODE_LEFT:     q_data.op = OP_LEFT;
			// a zero-length move only needs an acknowledgement
			MODE_MOVE:     q_data.op = (distance == '0) ? OP_NOP : OP_MOVE;
			MODE_DUMP:     q_data.op = OP_DUMP;
			MODE_EXIT:     q_data.op = OP_NOP;
			default:       q_data.op = OP_BAD;
		endcase
	end

endmodule

// ===== src/tpp_queue.sv =====
// Short command queue between front end and executor.
module tpp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tpp_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output tpp_pkg::cmd_t pop_data
);
	import tpp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/tpp_back.sv =====
// Executor: turtle state, floor memory, move and dump sequencing, result register.
module tpp_back #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_nonempty,
	input  tpp_pkg::cmd_t                   q_data,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tpp_pkg::KIND_W-1:0]      kind,
	output logic [tpp_pkg::CRD_W-1:0]       row_index,
	output logic [tpp_pkg::ROW_BITS_W-1:0]  row_bits,
	output logic [tpp_pkg::CRD_W-1:0]       pos_x,
	output logic [tpp_pkg::CRD_W-1:0]       pos_y,
	output logic [tpp_pkg::HEAD_W-1:0]      heading_out,
	output logic                            pen_out,
	output logic                            last
);
	import tpp_pkg::*;

	localparam int AW = $clog2(GRID_SIZE);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACK,
		S_MOVE,
		S_MOVE_WR,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	state_t              state_q;
	logic [CRD_W-1:0]    x_q;
	logic [CRD_W-1:0]    y_q;
	logic [HEAD_W-1:0]   head_q;
	logic                pen_q;
	logic [DIST_W-1:0]   steps_q;
	logic [CRD_W-1:0]    cnt_q;
	logic [KIND_W-1:0]   ack_kind_q;

	// floor store: one word per row, valid bits stand in for the reset clear
	logic [GRID_SIZE-1:0] floor_mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] row_vld_q;
	logic [GRID_SIZE-1:0] rd_row_s1;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_addr;
	logic [GRID_SIZE-1:0] rd_row;
	logic [GRID_SIZE-1:0] wr_row;
	logic                 mem_we;

	logic                 out_free;
	logic                 out_load;
	logic [CRD_W-1:0]     x_next;
	logic [CRD_W-1:0]     y_next;

	assign out_free = !out_valid || out_ready;
	assign out_load = ((state_q == S_ACK) || (state_q == S_DUMP_OUT)) && out_free;
	assign q_pop    = (state_q == S_IDLE) && q_nonempty;
	// keep reading the dumped row while its output beat waits
	assign rd_addr  = ((state_q == S_DUMP_RD) || (state_q == S_DUMP_OUT)) ?
		cnt_q[AW-1:0] : y_q[AW-1:0];
	assign rd_row   = rd_vld_s1 ? rd_row_s1 : '0;
	assign wr_row   = rd_row | (GRID_SIZE'(1) << x_q[AW-1:0]);
	assign mem_we   = (state_q == S_MOVE_WR);

	// one cell forward along the heading, wrapping at the edges
	always_comb begin
		x_next = x_q;
		y_next = y_q;
		unique case (head_q)
			HEAD_PX: x_next = (x_q == CRD_W'(GRID_SIZE - 1)) ? '0 : x_q + CRD_W'(1);
			HEAD_PY: y_next = (y_q == CRD_W'(GRID_SIZE - 1)) ? '0 : y_q + CRD_W'(1);
			HEAD_NX: x_next = (x_q == '0) ? CRD_W'(GRID_SIZE - 1) : x_q - CRD_W'(1);
			default: y_next = (y_q == '0) ? CRD_W'(GRID_SIZE - 1) : y_q - CRD_W'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			floor_mem[y_q[AW-1:0]] <= wr_row;
		end
		rd_row_s1 <= floor_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[y_q[AW-1:0]] <= 1'b1;
			end
			rd_vld_s1 <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= CRD_W'(GRID_SIZE / 2);
			y_q         <= CRD_W'(GRID_SIZE / 2);
			head_q      <= HEAD_PX;
			pen_q       <= 1'b0;
			steps_q     <= '0;
			cnt_q       <= '0;
			ack_kind_q  <= KIND_ACK;
			out_valid   <= 1'b0;
			kind        <= KIND_ACK;
			row_index   <= '0;
			row_bits    <= '0;
			pos_x       <= '0;
			pos_y       <= '0;
			heading_out <= '0;
			pen_out     <= 1'b0;
			last        <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_nonempty) begin
						ack_kind_q <= KIND_ACK;
						unique case (q_data.op)
							OP_PEN_UP: begin
								pen_q   <= 1'b0;
								state_q <= S_ACK;
							end
							OP_PEN_DOWN: begin
								pen_q   <= 1'b1;
								state_q <= S_ACK;
							end
							OP_RIGHT: begin
								head_q  <= head_q + HEAD_W'(1);
								state_q <= S_ACK;
							end
							OP_LEFT: begin
								head_q  <= head_q + HEAD_W'(3);
								state_q <= S_ACK;
							end
							OP_MOVE: begin
								steps_q <= q_data.move_len;
								state_q <= S_MOVE;
							end
							OP_DUMP: begin
								cnt_q   <= '0;
								state_q <= S_DUMP_RD;
							end
							OP_NOP: begin
								state_q <= S_ACK;
							end
							default: begin
								ack_kind_q <= KIND_BAD;
								state_q    <= S_ACK;
							end
						endcase
					end
				end
				S_ACK: begin
					if (out_free) begin
						kind        <= ack_kind_q;
						row_index   <= '0;
						row_bits    <= '0;
						pos_x       <= x_q;
						pos_y       <= y_q;
						heading_out <= head_q;
						pen_out     <= pen_q;
						last        <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_MOVE: begin
					// pen down: row read is in flight, mark on the next cycle
					if (pen_q) begin
						state_q <= S_MOVE_WR;
					end else begin
						x_q     <= x_next;
						y_q     <= y_next;
						steps_q <= steps_q - DIST_W'(1);
						state_q <= (steps_q == DIST_W'(1)) ? S_ACK : S_MOVE;
					end
				end
				S_MOVE_WR: begin
					x_q     <= x_next;
					y_q     <= y_next;
					steps_q <= steps_q - DIST_W'(1);
					state_q <= (steps_q == DIST_W'(1)) ? S_ACK : S_MOVE;
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					if (out_free) begin
						kind        <= KIND_ROW;
						row_index   <= cnt_q;
						row_bits    <= ROW_BITS_W'(rd_row);
						pos_x       <= x_q;
						pos_y       <= y_q;
						heading_out <= head_q;
						pen_out     <= pen_q;
						last        <= (cnt_q == CRD_W'(GRID_SIZE - 1));
						if (cnt_q == CRD_W'(GRID_SIZE - 1)) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + CRD_W'(1);
							state_q <= S_DUMP_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/turtle_pen_plotter_unit.sv =====
// Turtle pen plotter: command front end, queue and executor.
//
// Input channel: in_valid/in_ready carry one command per beat (mode, distance).
// Output channel: out_valid/out_ready carry one result per beat; last marks the
// final result of a command. Pen, turn, exit, invalid and zero-length move give
// one result; a dump gives GRID_SIZE row results, row 0 first.
// Commands pass a two-entry queue, so the front keeps accepting while the
// executor is busy or the receiver stalls; in_ready drops only when the queue
// is full.
// A simple command accepted into an empty block passes the queue, then the
// S_IDLE and S_ACK states, before it is loaded into the output register. With
// the pen up a move takes each step in S_MOVE alone; with the pen down each step
// passes S_MOVE (row read) and S_MOVE_WR (mark), a read-modify-write of the
// floor memory. Each dump row passes S_DUMP_RD (read), then S_DUMP_OUT (output load).
// A stalled receiver holds the output register and the executor waits on it.
// Reset clears the floor at once through per-row valid bits, places the turtle
// at the grid center facing +x with the pen up, and empties the queue.
module turtle_pen_plotter_unit #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tpp_pkg::MODE_W-1:0]      mode,
	input  logic [tpp_pkg::DIST_W-1:0]      distance,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tpp_pkg::KIND_W-1:0]      kind,
	output logic [tpp_pkg::CRD_W-1:0]       row_index,
	output logic [tpp_pkg::ROW_BITS_W-1:0]  row_bits,
	output logic [tpp_pkg::CRD_W-1:0]       pos_x,
	output logic [tpp_pkg::CRD_W-1:0]       pos_y,
	output logic [tpp_pkg::HEAD_W-1:0]      heading_out,
	output logic                            pen_out,
	output logic                            last
);
	import tpp_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_nonempty;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	tpp_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.distance (distance),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_cmd)
	);

	tpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (pop_cmd)
	);

	tpp_back #(
		.GRID_SIZE (GRID_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_data      (pop_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.heading_out (heading_out),
		.pen_out     (pen_out),
		.last        (last)
	);

endmodule

// ===== src/tpp_checker.sv =====
// Port-level checks of the turtle pen plotter, bound to the top level.
`include "turtle_pen_plotter_unit_assert.svh"

module tpp_checker #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [tpp_pkg::MODE_W-1:0]      mode,
	input logic [tpp_pkg::DIST_W-1:0]      distance,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tpp_pkg::KIND_W-1:0]      kind,
	input logic [tpp_pkg::CRD_W-1:0]       row_index,
	input logic [tpp_pkg::ROW_BITS_W-1:0]  row_bits,
	input logic [tpp_pkg::CRD_W-1:0]       pos_x,
	input logic [tpp_pkg::CRD_W-1:0]       pos_y,
	input logic [tpp_pkg::HEAD_W-1:0]      heading_out,
	input logic                            pen_out,
	input logic                            last
);
	import tpp_pkg::*;

	logic out_stall;
	logic ack_beat;
	logic row_beat;

	assign out_stall = out_valid && !out_ready;
	assign ack_beat  = out_valid && (kind == KIND_ACK || kind == KIND_BAD);
	assign row_beat  = out_valid && kind == KIND_ROW;

	// hold a stalled result beat
	`TPP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(row_bits) && $stable(last))
	// acknowledgements are single beats with no row payload
	`TPP_ASSERT_SAME(a_ack_single, ack_beat, last && row_index == '0 && row_bits == '0)
	// a dump ends exactly on the final row
	`TPP_ASSERT_SAME(a_row_last, row_beat, last == (row_index == CRD_W'(GRID_SIZE - 1)))
	// no marked cells beyond the grid width
	`TPP_ASSERT_SAME(a_row_width, row_beat,
		(row_bits >> GRID_SIZE) == ROW_BITS_W'(0) || GRID_SIZE == ROW_BITS_W)

	logic unused_ok;
	assign unused_ok = ^{in_valid, in_ready, mode, distance, pos_x, pos_y, heading_out, pen_out};

endmodule

bind turtle_pen_plotter_unit tpp_checker #(.GRID_SIZE(GRID_SIZE)) u_tpp_checker (.*);
